>>> src/mpt_pkg.sv
// ----------------------------------------------------------------------------
// mpt_pkg
// Shared types and constants of the microsecond period timer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpt_pkg;

	// input item kinds, carried on s_tuser
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_SET   = 2'd3
	} action_t;

	// configuration register indexes (byte address = 4 * index)
	localparam int unsigned APB_ADDR_W = 4;
	localparam logic [1:0] REG_CLOCK_MHZ  = 2'd0;
	localparam logic [1:0] REG_MIN_PERIOD = 2'd1;
	localparam logic [1:0] REG_MAX_PERIOD = 2'd2;
	localparam logic [1:0] REG_ONE_SHOT   = 2'd3;

	localparam logic [7:0]  RST_CLOCK_MHZ  = 8'd96;
	localparam logic [25:0] RST_MIN_PERIOD = 26'd10;
	localparam logic [31:0] RST_MAX_PERIOD = 32'd40000000;

	localparam int unsigned DATA_IN_W  = 32;
	localparam int unsigned DATA_OUT_W = 72;

	typedef struct packed {
		logic [7:0]  timer_clock_mhz;
		logic [25:0] min_period_us;
		logic [31:0] max_period_us;
		logic        one_shot;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic exec;        // tick, start or stop: update and post result
		logic capture;     // latch requested period
		logic mul;         // form ticks and range check
		logic reject;      // post refused result
		logic div_start;   // load divider
		logic div_step;    // one quotient bit
		logic div_finish;  // commit period, post result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_space;
		logic refuse;
		logic div_last;
		logic running;
	} sts_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL    = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

endpackage

`default_nettype wire

>>> src/microsecond_period_timer.sv
// ----------------------------------------------------------------------------
// microsecond_period_timer: prescaler and reload periodic timer
// Tick, start, stop: result the cycle after acceptance, one per cycle unless output stalls.
// Set period: a request refused by the limit checks posts its result from the
// check state; otherwise the 32-step restoring divider forms the reload, one item at a time.
// Reset (arst_n low) stops the timer, clears counters and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module microsecond_period_timer #(
	parameter int unsigned COUNTER_WIDTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// APB configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // [31:0] requested period (us)
	input  wire logic [1:0]   s_tuser,   // [1:0] action
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [71:0]       m_tdata    // [0] expired, [32:1] expiry_count,
	                                     // [33] running_now, [34] status,
	                                     // [50:35] prescale_value, [66:51] reload_value
);
	import mpt_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	mpt_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	mpt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.action  (s_tuser),
		.sts     (sts),
		.cmd     (cmd)
	);

	mpt_dp #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.action   (s_tuser),
		.req_us   (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == ACT_START) |=> sts.running)
		else $error("timer not running after start");

	a_set_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == ACT_SET) |=> !s_tready)
		else $error("input taken during period conversion");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.reject || cmd.div_finish) |-> sts.out_space)
		else $error("result register overwritten");

	a_count_on_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tdata[32:1] != $past(m_tdata[32:1])) |-> (m_tvalid && m_tdata[0]))
		else $error("expiry count changed without expiry");
`endif

endmodule

`default_nettype wire

>>> src/mpt_regs.sv
// ----------------------------------------------------------------------------
// mpt_regs
// APB configuration registers of the microsecond period timer.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mpt_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output mpt_pkg::cfg_t                     cfg
);
	import mpt_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_clock_mhz <= RST_CLOCK_MHZ;
			cfg_q.min_period_us   <= RST_MIN_PERIOD;
			cfg_q.max_period_us   <= RST_MAX_PERIOD;
			cfg_q.one_shot        <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CLOCK_MHZ:  cfg_q.timer_clock_mhz <= pwdata[7:0];
				REG_MIN_PERIOD: cfg_q.min_period_us   <= pwdata[25:0];
				REG_MAX_PERIOD: cfg_q.max_period_us   <= pwdata;
				REG_ONE_SHOT:   cfg_q.one_shot        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CLOCK_MHZ:  prdata = {24'd0, cfg_q.timer_clock_mhz};
			REG_MIN_PERIOD: prdata = {6'd0, cfg_q.min_period_us};
			REG_MAX_PERIOD: prdata = cfg_q.max_period_us;
			REG_ONE_SHOT:   prdata = {31'd0, cfg_q.one_shot};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

>>> src/mpt_ctrl.sv
// ----------------------------------------------------------------------------
// mpt_ctrl
// Sequencer: timer commands from idle, multi-state period conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [1:0]   action,
	input  mpt_pkg::sts_t     sts,
	output mpt_pkg::cmd_t     cmd
);
	import mpt_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && sts.out_space;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action_t'(action) == ACT_SET) begin
						cmd.capture = 1'b1;
						state_d     = ST_MUL;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.refuse) begin
					cmd.reject = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.div_finish = 1'b1;
				state_d        = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

>>> src/mpt_dp.sv
// ----------------------------------------------------------------------------
// mpt_dp
// Timer counters, period conversion datapath and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_dp #(
	parameter int unsigned COUNTER_WIDTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  mpt_pkg::cfg_t                         cfg,
	input  mpt_pkg::cmd_t                         cmd,
	output mpt_pkg::sts_t                         sts,
	input  wire logic [1:0]                       action,
	input  wire logic [mpt_pkg::DATA_IN_W-1:0]    req_us,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [mpt_pkg::DATA_OUT_W-1:0]        m_tdata
);
	import mpt_pkg::*;

	localparam int unsigned CW = COUNTER_WIDTH;
	localparam logic [40:0] CNT_MAX    = (41'd1 << CW) - 41'd1;
	// largest product that still leaves room for the round-up add
	localparam logic [39:0] TICK_LIMIT = 40'h00_FFFF_FFFF - CNT_MAX[39:0];

	// timer state
	logic [CW-1:0] psc_cnt_q, main_cnt_q;
	logic [CW-1:0] act_psc_q, act_arr_q;
	logic [CW-1:0] pend_psc_q, pend_arr_q;
	logic          running_q;
	logic [31:0]   total_q;
	logic          out_valid_q, expired_q, status_q;

	// period conversion
	logic [31:0] us_q;
	logic [39:0] ticks_q;
	logic        range_bad_q;
	logic [31:0] div_q, quo_q, rem_q;
	logic [4:0]  cnt_q;

	logic        psc_wrap, main_wrap, expire_now, load;
	logic [40:0] round_up;
	logic [32:0] trial;
	logic        take;
	logic        quo_small;

	assign psc_wrap   = psc_cnt_q >= act_psc_q;
	assign main_wrap  = main_cnt_q >= act_arr_q;
	assign expire_now = cmd.exec && (action_t'(action) == ACT_TICK) && running_q
		&& psc_wrap && main_wrap;
	assign load       = cmd.exec || cmd.reject || cmd.div_finish;

	assign round_up  = {1'b0, ticks_q} + CNT_MAX;
	assign trial     = {rem_q, quo_q[31]};
	assign take      = trial >= {1'b0, div_q};
	assign quo_small = quo_q < 32'd2;

	assign sts.out_space = !out_valid_q || m_tready;
	assign sts.refuse    = range_bad_q || (ticks_q > TICK_LIMIT) || (ticks_q < 40'd2);
	assign sts.div_last  = cnt_q == 5'd31;
	assign sts.running   = running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psc_cnt_q   <= '0;
			main_cnt_q  <= '0;
			act_psc_q   <= '0;
			act_arr_q   <= '0;
			pend_psc_q  <= '0;
			pend_arr_q  <= '0;
			running_q   <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			if (cmd.exec) begin
				unique case (action_t'(action))
					ACT_TICK: begin
						if (running_q) begin
							if (psc_wrap) begin
								psc_cnt_q <= '0;
								if (main_wrap) begin
									main_cnt_q <= '0;
									total_q    <= total_q + 32'd1;
									act_psc_q  <= pend_psc_q;
									act_arr_q  <= pend_arr_q;
									if (cfg.one_shot)
										running_q <= 1'b0;
								end else begin
									main_cnt_q <= main_cnt_q + CW'(1);
								end
							end else begin
								psc_cnt_q <= psc_cnt_q + CW'(1);
							end
						end
					end
					ACT_START: begin
						psc_cnt_q  <= '0;
						main_cnt_q <= '0;
						act_psc_q  <= pend_psc_q;
						act_arr_q  <= pend_arr_q;
						running_q  <= 1'b1;
					end
					ACT_STOP: running_q <= 1'b0;
					default: ;
				endcase
			end

			if (cmd.div_finish && !quo_small) begin
				pend_psc_q <= CW'(div_q - 32'd1);
				pend_arr_q <= CW'(quo_q - 32'd1);
			end
		end
	end

	// result flags and conversion payload
	always_ff @(posedge clk) begin
		if (load) begin
			expired_q <= expire_now;
			status_q  <= cmd.reject || (cmd.div_finish && quo_small);
		end
		if (cmd.capture)
			us_q <= req_us;
		if (cmd.mul) begin
			ticks_q     <= {8'd0, us_q} * {32'd0, cfg.timer_clock_mhz};
			range_bad_q <= (us_q < {6'd0, cfg.min_period_us})
				|| (us_q > cfg.max_period_us) || (cfg.timer_clock_mhz == 8'd0);
		end
		if (cmd.div_start) begin
			div_q <= 32'(round_up >> CW);
			quo_q <= ticks_q[31:0];
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			// restoring division, one quotient bit per cycle
			rem_q <= take ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], take};
			cnt_q <= cnt_q + 5'd1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, 16'(pend_arr_q), 16'(pend_psc_q), status_q, running_q,
		total_q, expired_q};

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb - microsecond_period_timer testbench
// Drives tick/start/stop/set-period transactions on the input stream and
// checks every result against a cycle-free model of the prescaler/reload
// timer. Covers period limits, refusals and one-shot mode, plus a prescaled
// period and randomized register settings. Both stream sides
// stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mpt_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 1_500_000;
	localparam int unsigned SETTLE_CYCLES   = 40;
	localparam int unsigned RANDOM_PHASES   = 8;
	localparam int unsigned ITEMS_PER_PHASE = 230;
	localparam int unsigned PRINT_CAP       = 100;

	// m_tdata layout, lowest bit last
	typedef struct packed {
		logic [4:0]  pad;
		logic [15:0] reload;
		logic [15:0] prescale;
		logic        status;
		logic        running;
		logic [31:0] expiries;
		logic        expired;
	} timer_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] requested period (us)
	logic [1:0]  s_tuser;   // [1:0] action
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // [0] expired, [32:1] expiry_count, [33] running_now,
	                        // [34] status, [50:35] prescale_value, [66:51] reload_value

	// model copy of registers and timer state
	logic [7:0]  cfg_clock_mhz = RST_CLOCK_MHZ;
	logic [25:0] cfg_min_us    = RST_MIN_PERIOD;
	logic [31:0] cfg_max_us    = RST_MAX_PERIOD;
	logic        cfg_one_shot  = 1'b0;
	logic [15:0] psc_count     = '0;
	logic [15:0] main_count    = '0;
	logic [15:0] active_psc    = '0;
	logic [15:0] active_arr    = '0;
	logic [15:0] pending_psc   = '0;
	logic [15:0] pending_arr   = '0;
	logic        timer_running = 1'b0;
	logic [31:0] expiry_total  = '0;

	timer_result_t expected_results[$];
	int unsigned   mismatches  = 0;
	int unsigned   cycle_count = 0;
	bit            idle_on     = 1'b1;

	microsecond_period_timer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// smallest prescaler that fits, reload from the quotient
	function automatic logic derive_prescale(input logic [31:0] us, output logic [15:0] psc,
			output logic [15:0] arr);
		logic [63:0] ticks;
		logic [63:0] div;
		psc = '0;
		arr = '0;
		if (us < 32'(cfg_min_us) || us > cfg_max_us || cfg_clock_mhz == 8'd0)
			return 1'b0;
		if (64'(us) > (64'hFFFF_FFFF - 64'hFFFF) / 64'(cfg_clock_mhz))
			return 1'b0;
		ticks = 64'(us) * 64'(cfg_clock_mhz);
		if (ticks < 64'd2)
			return 1'b0;
		div   = (ticks + 64'hFFFF) >> 16;
		ticks = ticks / div;
		if (ticks < 64'd2)
			return 1'b0;
		psc = 16'(div - 64'd1);
		arr = 16'(ticks - 64'd1);
		return 1'b1;
	endfunction

	function automatic timer_result_t predict_timer_step(input action_t act,
			input logic [31:0] us);
		timer_result_t res;
		logic [15:0]   psc;
		logic [15:0]   arr;
		res = '0;
		case (act)
		ACT_TICK: begin
			if (timer_running) begin
				if (psc_count >= active_psc) begin
					psc_count = '0;
					if (main_count >= active_arr) begin
						main_count   = '0;
						res.expired  = 1'b1;
						expiry_total = expiry_total + 32'd1;
						active_psc   = pending_psc;
						active_arr   = pending_arr;
						if (cfg_one_shot)
							timer_running = 1'b0;
					end else begin
						main_count = main_count + 16'd1;
					end
				end else begin
					psc_count = psc_count + 16'd1;
				end
			end
		end
		ACT_START: begin
			psc_count     = '0;
			main_count    = '0;
			active_psc    = pending_psc;
			active_arr    = pending_arr;
			timer_running = 1'b1;
		end
		ACT_STOP: begin
			timer_running = 1'b0;
		end
		ACT_SET: begin
			if (derive_prescale(us, psc, arr)) begin
				pending_psc = psc;
				pending_arr = arr;
			end else begin
				res.status = 1'b1;
			end
		end
		endcase
		res.expiries = expiry_total;
		res.running  = timer_running;
		res.prescale = pending_psc;
		res.reload   = pending_arr;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("tb: mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
				cycle_count, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		timer_result_t got;
		timer_result_t want;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got = m_tdata;
			if (expected_results.size() == 0) begin
				report_mismatch("result with none pending", got.expiries, '0);
			end else begin
				want = expected_results.pop_front();
				check_field("expired", 32'(got.expired), 32'(want.expired));
				check_field("expiry_count", got.expiries, want.expiries);
				check_field("running_now", 32'(got.running), 32'(want.running));
				check_field("status", 32'(got.status), 32'(want.status));
				check_field("prescale_value", 32'(got.prescale), 32'(want.prescale));
				check_field("reload_value", 32'(got.reload), 32'(want.reload));
				check_field("tdata padding", 32'(got.pad), 32'(want.pad));
			end
		end
	end

	// result side back-pressure
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 11) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input action_t act, input logic [31:0] us);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= us;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(predict_timer_step(act, us));
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write, then read back the masked value
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		case (idx)
		REG_CLOCK_MHZ: begin
			mask          = 32'h0000_00FF;
			cfg_clock_mhz = value[7:0];
		end
		REG_MIN_PERIOD: begin
			mask       = 32'h03FF_FFFF;
			cfg_min_us = value[25:0];
		end
		REG_MAX_PERIOD: begin
			mask       = 32'hFFFF_FFFF;
			cfg_max_us = value;
		end
		REG_ONE_SHOT: begin
			mask         = 32'h0000_0001;
			cfg_one_shot = value[0];
		end
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== (value & mask))
			report_mismatch("register readback", prdata, value & mask);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] mhz, input logic [25:0] min_us,
			input logic [31:0] max_us, input logic one_shot);
		write_reg(REG_CLOCK_MHZ, 32'(mhz));
		write_reg(REG_MIN_PERIOD, 32'(min_us));
		write_reg(REG_MAX_PERIOD, max_us);
		write_reg(REG_ONE_SHOT, 32'(one_shot));
	endtask

	// buffered values are still zero, so each running tick expires
	task automatic test_start_without_period();
		send_item(ACT_TICK, 32'hFFFF_FFFF);
		send_item(ACT_STOP, '0);
		send_item(ACT_START, '0);
		send_item(ACT_TICK, '0);
		send_item(ACT_TICK, 32'hA5A5_5A5A);
		send_item(ACT_TICK, '0);
		send_item(ACT_START, '0);
		send_item(ACT_TICK, '0);
		send_item(ACT_STOP, '0);
		send_item(ACT_TICK, '0);
	endtask

	// reset register values: limits 10 and 40000000 us at 96 MHz
	task automatic test_period_limits();
		send_item(ACT_SET, 32'd0);
		send_item(ACT_SET, 32'd9);
		send_item(ACT_SET, 32'd10);
		send_item(ACT_SET, 32'd40_000_000);
		send_item(ACT_SET, 32'd40_000_001);
		send_item(ACT_SET, 32'hFFFF_FFFF);
		send_item(ACT_SET, 32'd1000);
		wait_results_drained();
		send_item(ACT_START, '0);
		send_item(ACT_TICK, '0);
	endtask

	task automatic test_refusal_cases();
		wait_results_drained();
		// overflow bound: (2^32-1 - 0xFFFF) / 255 = 16842752
		configure(8'd255, 26'd1, 32'hFFFF_FFFF, 1'b1);
		send_item(ACT_SET, 32'd16_842_752);
		send_item(ACT_SET, 32'd16_842_753);
		wait_results_drained();
		configure(8'd1, 26'd1, 32'hFFFF_FFFF, 1'b0);
		send_item(ACT_SET, 32'd1);
		send_item(ACT_SET, 32'd2);
		wait_results_drained();
		write_reg(REG_CLOCK_MHZ, 32'd0);
		send_item(ACT_SET, 32'd5);
	endtask

	// psc 1, arr 32768: the main counter moves on every second tick; then a
	// 4-tick period runs to its one-shot expiry and stops
	task automatic test_prescaled_period();
		wait_results_drained();
		configure(8'd1, 26'd1, 32'hFFFF_FFFF, 1'b1);
		idle_on = 1'b0;
		send_item(ACT_SET, 32'd65_538);
		send_item(ACT_START, $urandom);
		repeat (40) send_item(ACT_TICK, $urandom);
		send_item(ACT_STOP, $urandom);
		send_item(ACT_SET, 32'd4);
		send_item(ACT_START, $urandom);
		repeat (8) send_item(ACT_TICK, $urandom);
		wait_results_drained();
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int unsigned pick;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_results_drained();
			case (p)
			0: configure(8'd1, 26'd1, 32'hFFFF_FFFF, 1'b0);
			1: configure(8'd1, 26'd1, 32'd1000, 1'b1);
			2: configure(8'd255, 26'd1, 32'hFFFF_FFFF, 1'b0);
			3: configure(8'($urandom_range(1, 255)), 26'd40_000_000, 32'd1,
					1'($urandom_range(0, 1)));
			default: configure(8'($urandom_range(1, 4)), 26'($urandom_range(1, 3)),
					$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(2, 5000)),
					1'($urandom_range(0, 1)));
			endcase
			idle_on = (p != RANDOM_PHASES - 1);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					send_item(ACT_TICK, $urandom);
				else if (pick < 82)
					send_item(ACT_START, $urandom);
				else if (pick < 87)
					send_item(ACT_STOP, $urandom);
				else if (pick < 95)
					send_item(ACT_SET, $urandom_range(1, 40));
				else if (pick < 98)
					send_item(ACT_SET, $urandom_range(1, 200_000));
				else
					send_item(ACT_SET, $urandom);
			end
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= ACT_TICK;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_start_without_period();
		test_period_limits();
		test_refusal_cases();
		test_prescaled_period();
		test_random_traffic();
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
